### src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define QPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define QPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/qpd_pkg.sv
package qpd_pkg;

   // Phase pair codes, phase A in bit 0 and phase B in bit 1
   localparam logic [1:0] PHASE_00 = 2'b00;
   localparam logic [1:0] PHASE_01 = 2'b01;
   localparam logic [1:0] PHASE_11 = 2'b11;
   localparam logic [1:0] PHASE_10 = 2'b10;

   localparam int COUNT_WIDTH_DEF   = 16;
   localparam int TRAVEL_WIDTH      = 15;
   localparam int OUT_COUNT_WIDTH   = 16;
   localparam logic [TRAVEL_WIDTH-1:0] MIN_TRAVEL_RESET = 15'd40;

   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 24;

   // Direction codes
   localparam logic DIR_REVERSE = 1'b0;
   localparam logic DIR_FORWARD = 1'b1;

   // Gray-code step forward: 01->11->10->00->01
   function automatic logic step_fwd(input logic [1:0] from, input logic [1:0] to);
      return (from == PHASE_01 && to == PHASE_11) || (from == PHASE_11 && to == PHASE_10) ||
             (from == PHASE_10 && to == PHASE_00) || (from == PHASE_00 && to == PHASE_01);
   endfunction

   // Gray-code step in reverse: 01->00->10->11->01
   function automatic logic step_rev(input logic [1:0] from, input logic [1:0] to);
      return (from == PHASE_01 && to == PHASE_00) || (from == PHASE_00 && to == PHASE_10) ||
             (from == PHASE_10 && to == PHASE_11) || (from == PHASE_11 && to == PHASE_01);
   endfunction

endpackage

### src/quadrature_pass_detector_unit.sv
// Quadrature pass detector: X4 decoder with pass validation.
// Request channel (req_*): one pin-change event per request. tuser carries the
// phase-edge flag (0 = no phase change, state is left alone), tdata the phase
// levels and tlast the index level, which ends a pass.
// Response channel (rsp_*): exactly one response per request, reporting the
// pass level, the up/down indicators, the signed position and the error latch
// as they stand after that request.
// Config channel (csr_*): writes min_travel; always ready. Write only while idle.
// The response is valid in the cycle after its request is accepted; a new request
// is taken every cycle while the receiver keeps up, as the whole update is one
// combinational step between the state registers and the response register.
// When the receiver stalls, the response register holds its data and
// req_tready stays high only if the pending response is taken in that cycle.
// Reset clears the position, phases, directions, error and indicator levels,
// loads min_travel with 40 and empties the response register.
`include "assert_macros.svh"

module quadrature_pass_detector_unit #(
   parameter int COUNT_WIDTH = qpd_pkg::COUNT_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [qpd_pkg::REQ_DATA_WIDTH-1:0] req_tdata,  // [0] phase_a, [1] phase_b
   input  logic                               req_tuser,  // [0] phase_edge
   input  logic                               req_tlast,  // index_level
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] pass_out, [1] up_indicator, [2] down_indicator, [18:3] count,
   // [19] reversal_error
   output logic [qpd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // config channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [qpd_pkg::TRAVEL_WIDTH-1:0]   csr_data
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > qpd_pkg::TRAVEL_WIDTH) ?
                              COUNT_WIDTH : qpd_pkg::TRAVEL_WIDTH;
   localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   // state
   logic signed [COUNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [1:0]                        prev_ff, prev_in;
   logic                              cur_dir_ff, cur_dir_in;
   logic                              pass_dir_ff, pass_dir_in;
   logic                              err_ff, err_in;
   logic                              pass_ff, pass_in;
   logic                              up_ff, up_in;
   logic                              down_ff, down_in;
   logic [qpd_pkg::TRAVEL_WIDTH-1:0]  travel_ff;
   logic                              rsp_valid_ff;
   logic [qpd_pkg::RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                              req_acc;
   logic [1:0]                        phases;
   logic [COUNT_WIDTH-1:0]            mag;
   logic [CMP_WIDTH-1:0]              mag_ext, travel_ext;
   logic signed [qpd_pkg::OUT_COUNT_WIDTH-1:0] count_out;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign phases     = req_tdata[1:0];
   assign mag        = cnt_ff[COUNT_WIDTH-1] ? COUNT_WIDTH'(-cnt_ff) : COUNT_WIDTH'(cnt_ff);
   assign mag_ext    = CMP_WIDTH'(mag);
   assign travel_ext = CMP_WIDTH'(travel_ff);

   // next state for one pin-change event
   always_comb begin
      cnt_in      = cnt_ff;
      prev_in     = prev_ff;
      cur_dir_in  = cur_dir_ff;
      pass_dir_in = pass_dir_ff;
      err_in      = err_ff;
      pass_in     = pass_ff;
      up_in       = up_ff;
      down_in     = down_ff;
      if (req_tuser) begin
         // index ends the pass
         if (req_tlast) begin
            if (!err_ff && (mag_ext > travel_ext)) begin
               pass_in = !pass_ff;
               cnt_in  = '0;
            end
            err_in      = 1'b0;
            pass_dir_in = cur_dir_ff;
         end
         // decode one Gray step
         if (!err_in && (phases != prev_ff)) begin
            if (qpd_pkg::step_fwd(prev_ff, phases)) begin
               up_in      = !req_tlast;
               down_in    = 1'b0;
               cur_dir_in = qpd_pkg::DIR_FORWARD;
               if (cnt_in < CNT_MAX) cnt_in = cnt_in + COUNT_WIDTH'(1);
            end else if (qpd_pkg::step_rev(prev_ff, phases)) begin
               down_in    = !req_tlast;
               up_in      = 1'b0;
               cur_dir_in = qpd_pkg::DIR_REVERSE;
               if (cnt_in > CNT_MIN) cnt_in = cnt_in - COUNT_WIDTH'(1);
            end
            // reversal inside a pass
            if ((cur_dir_in != pass_dir_in) && !req_tlast) begin
               err_in  = 1'b1;
               up_in   = 1'b1;
               down_in = 1'b1;
            end
            prev_in = phases;
         end
      end
   end

   // response packing
   assign count_out   = qpd_pkg::OUT_COUNT_WIDTH'(cnt_in);
   assign rsp_data_in = {4'b0000, err_in, count_out, down_in, up_in, pass_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         prev_ff      <= qpd_pkg::PHASE_00;
         cur_dir_ff   <= qpd_pkg::DIR_REVERSE;
         pass_dir_ff  <= qpd_pkg::DIR_REVERSE;
         err_ff       <= 1'b0;
         pass_ff      <= 1'b0;
         up_ff        <= 1'b0;
         down_ff      <= 1'b0;
         travel_ff    <= qpd_pkg::MIN_TRAVEL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            travel_ff <= csr_data;
         end
         if (req_acc) begin
            cnt_ff       <= cnt_in;
            prev_ff      <= prev_in;
            cur_dir_ff   <= cur_dir_in;
            pass_dir_ff  <= pass_dir_in;
            err_ff       <= err_in;
            pass_ff      <= pass_in;
            up_ff        <= up_in;
            down_ff      <= down_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `QPD_ASSERT(a_err_sets_both, clock, reset, err_ff |-> (up_ff && down_ff), "error latched without both indicators")
   `QPD_ASSERT(a_cnt_idle, clock, reset, !req_acc |=> $stable(cnt_ff), "count moved without a request")
   `QPD_ASSERT(a_pass_on_index, clock, reset, !(req_acc && req_tlast) |=> $stable(pass_ff), "pass level toggled without index")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int COUNT_MAX  = (1 << (qpd_pkg::COUNT_WIDTH_DEF - 1)) - 1;
   localparam int COUNT_MIN  = -(1 << (qpd_pkg::COUNT_WIDTH_DEF - 1));
   localparam int TRAVEL_MAX = (1 << qpd_pkg::TRAVEL_WIDTH) - 1;

   // Gray ring in forward order; one position up is a forward step
   localparam logic [1:0] GRAY_RING [4] = '{qpd_pkg::PHASE_00, qpd_pkg::PHASE_01,
                                            qpd_pkg::PHASE_11, qpd_pkg::PHASE_10};

   // Response fields, pass level in bit 0
   typedef struct packed {
      logic                                rev_err;
      logic [qpd_pkg::OUT_COUNT_WIDTH-1:0] count;
      logic                                down_ind;
      logic                                up_ind;
      logic                                pass_out;
   } pass_result_type;

   // Tracks decoder state per accepted request and checks responses in order
   class travel_scoreboard;
      int              fails;
      int              min_travel;
      int              position;
      logic [1:0]      prev_phases;
      logic            cur_dir, pass_dir, err_latched, pass_lvl, up_lvl, down_lvl;
      pass_result_type expected_q[$];

      function new();
         fails       = 0;
         min_travel  = qpd_pkg::MIN_TRAVEL_RESET;
         position    = 0;
         prev_phases = qpd_pkg::PHASE_00;
         cur_dir     = qpd_pkg::DIR_REVERSE;
         pass_dir    = qpd_pkg::DIR_REVERSE;
         err_latched = 0;
         pass_lvl    = 0;
         up_lvl      = 0;
         down_lvl    = 0;
      endfunction

      function void set_travel(int value);
         min_travel = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int ring_pos(logic [1:0] ph);
         case (ph)
            qpd_pkg::PHASE_00: return 0;
            qpd_pkg::PHASE_01: return 1;
            qpd_pkg::PHASE_11: return 2;
            default:           return 3;
         endcase
      endfunction

      function void note_request(logic has_edge, logic [1:0] ph, logic idx);
         int              span;
         int              mag;
         pass_result_type r;
         if (has_edge) begin
            // index ends the pass: count it if clean and long enough
            if (idx) begin
               mag = (position < 0) ? -position : position;
               if (!err_latched && mag > min_travel) begin
                  pass_lvl = ~pass_lvl;
                  position = 0;
               end
               err_latched = 0;
               pass_dir    = cur_dir;
            end
            // decode only when running and the phases moved
            if (!err_latched && ph != prev_phases) begin
               span = (ring_pos(ph) - ring_pos(prev_phases)) & 3;
               if (span == 1) begin
                  up_lvl   = !idx;
                  down_lvl = 0;
                  cur_dir  = qpd_pkg::DIR_FORWARD;
                  if (position < COUNT_MAX) position++;
               end else if (span == 3) begin
                  down_lvl = !idx;
                  up_lvl   = 0;
                  cur_dir  = qpd_pkg::DIR_REVERSE;
                  if (position > COUNT_MIN) position--;
               end
               if (cur_dir != pass_dir && !idx) begin
                  err_latched = 1;
                  up_lvl      = 1;
                  down_lvl    = 1;
               end
               prev_phases = ph;
            end
         end
         r.pass_out = pass_lvl;
         r.up_ind   = up_lvl;
         r.down_ind = down_lvl;
         r.count    = position[qpd_pkg::OUT_COUNT_WIDTH-1:0];
         r.rev_err  = err_latched;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
         end
      endfunction

      function void check_response(logic [19:0] raw);
         pass_result_type got, want;
         got = raw;
         if (expected_q.size() == 0) begin
            $display("%0t: response with no request pending, expected none, actual %h",
                     $time, raw);
            fails++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("pass_out", want.pass_out, got.pass_out);
         compare_field("up_indicator", want.up_ind, got.up_ind);
         compare_field("down_indicator", want.down_ind, got.down_ind);
         compare_field("count", $signed(want.count), $signed(got.count));
         compare_field("reversal_error", want.rev_err, got.rev_err);
      endfunction
   endclass

   logic                               clock = 0;
   logic                               reset = 1;
   logic                               req_tvalid = 0;
   logic                               req_tready;
   logic [qpd_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                               req_tuser = 0;
   logic                               req_tlast = 0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 0;
   logic [qpd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                               csr_valid = 0;
   logic                               csr_ready;
   logic [qpd_pkg::TRAVEL_WIDTH-1:0]   csr_data = '0;

   travel_scoreboard sb = new();
   int               edge_items = 0;
   bit               idle_on = 1;
   bit               hold_req = 0;

   quadrature_pass_detector_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Response check on every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata[19:0]);
   end

   // Receiver: random stalls, plus one long hold-off on demand
   initial begin : rsp_side
      int stall;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 0;
            rsp_tready <= 0;
            repeat (300) @(negedge clock);
         end
         stall = idle_on ? $urandom_range(0, 17) : 0;
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // Offer one request; returns at the edge that accepted it
   task automatic send_event(input logic has_edge, input logic [1:0] ph, input logic idx);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= has_edge;
      req_tdata  <= {{(qpd_pkg::REQ_DATA_WIDTH - 2){1'b0}}, ph};
      req_tlast  <= idx;
      do @(posedge clock); while (!req_tready);
      sb.note_request(has_edge, ph, idx);
      if (has_edge) edge_items++;
   endtask

   // One Gray step from the stored phases
   task automatic move(input logic dir, input logic idx);
      int pos;
      pos = sb.ring_pos(sb.prev_phases) + ((dir == qpd_pkg::DIR_FORWARD) ? 1 : 3);
      send_event(1'b1, GRAY_RING[2'(pos)], idx);
   endtask

   // Drop valid and let every expected response drain
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_travel(input logic [qpd_pkg::TRAVEL_WIDTH-1:0] value);
      csr_valid <= 1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_travel(value);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Clean pass: align direction at an index, run one way, end at an index
   task automatic run_pass();
      int   steps;
      logic dir;
      send_event(1'b1, sb.prev_phases, 1'b1);
      dir = sb.cur_dir;
      if (sb.min_travel < 60 && $urandom_range(0, 3) != 0)
         steps = sb.min_travel + int'($urandom_range(0, 4)) - 2;
      else
         steps = int'($urandom_range(1, 40));
      if (steps < 1) steps = 1;
      repeat (steps) begin
         if ($urandom_range(0, 15) == 0)
            send_event(1'b0, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         move(dir, 1'b0);
      end
      if ($urandom_range(0, 2) == 0) move(dir, 1'b1);
      else send_event(1'b1, sb.prev_phases, 1'b1);
   endtask

   task automatic random_segment();
      int pick;
      int n;
      idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         run_pass();
      end else if (pick < 72) begin
         // turn around, either under the index or into a reversal error
         move(!sb.cur_dir, 1'($urandom_range(0, 1)));
      end else if (pick < 82) begin
         send_event(1'b1, sb.prev_phases ^ 2'b11, $urandom_range(0, 3) == 0);
      end else begin
         n = $urandom_range(1, 8);
         repeat (n) send_event(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 40) == 0) wait_idle();
   endtask

   initial begin : stimulus
      int travel_plan[4];
      int stop_at;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: ignored items, index, pass, double step, error handling
      idle_on = 1;
      write_travel(qpd_pkg::TRAVEL_WIDTH'(2));
      send_event(1'b0, qpd_pkg::PHASE_11, 1'b1);
      send_event(1'b0, qpd_pkg::PHASE_00, 1'b0);
      send_event(1'b1, qpd_pkg::PHASE_00, 1'b1);
      repeat (3) move(qpd_pkg::DIR_REVERSE, 1'b0);
      send_event(1'b1, sb.prev_phases, 1'b1);
      send_event(1'b1, sb.prev_phases ^ 2'b11, 1'b0);
      move(qpd_pkg::DIR_FORWARD, 1'b1);
      move(qpd_pkg::DIR_FORWARD, 1'b0);
      move(qpd_pkg::DIR_FORWARD, 1'b0);
      send_event(1'b1, sb.prev_phases, 1'b0);
      send_event(1'b1, sb.prev_phases, 1'b1);
      repeat (4) move(qpd_pkg::DIR_FORWARD, 1'b0);
      move(qpd_pkg::DIR_FORWARD, 1'b1);
      move(qpd_pkg::DIR_FORWARD, 1'b0);
      send_event(1'b1, sb.prev_phases, 1'b1);

      // random phases under several travel thresholds
      travel_plan[0] = 0;
      travel_plan[1] = $urandom_range(1, 30);
      travel_plan[2] = qpd_pkg::MIN_TRAVEL_RESET;
      travel_plan[3] = $urandom_range(3, 12);
      foreach (travel_plan[i]) begin
         wait_idle();
         write_travel(qpd_pkg::TRAVEL_WIDTH'(travel_plan[i]));
         stop_at = edge_items + 330;
         if (i == 1) begin
            // long receiver hold-off while requests keep coming
            hold_req = 1;
            idle_on  = 0;
            repeat (3) run_pass();
         end
         while (edge_items < stop_at) random_segment();
      end

      // a pass that stays below the largest threshold
      wait_idle();
      write_travel(qpd_pkg::TRAVEL_WIDTH'(TRAVEL_MAX));
      idle_on = 0;
      run_pass();

      wait_idle();
      repeat (5) @(negedge clock);
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/qpd_pkg.sv
src/quadrature_pass_detector_unit.sv
bench/tb_top.sv
